### hdl/bmnp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmnp_pkg
// Shared constants, types and helpers of the Box-Muller normal pair sampler.
// ----------------------------------------------------------------------------
package bmnp_pkg;

    localparam int FRAC_BITS = 20;
    localparam int RND_SH    = 52 - FRAC_BITS;

    localparam logic [31:0] LN2_Q32    = 32'hB172_17F8;
    localparam logic [34:0] TWO_PI_Q32 = 35'h6_487E_D511;
    localparam logic [12:0] SCALE_RST  = 13'd1024;

    localparam int LOG_STEPS  = 32;
    localparam int SQRT_STEPS = 32;
    localparam int TERMS      = 6;
    localparam int TRIG_DLY   = 52;
    localparam int N_STAGES   = 71;

    // Divisors of the cosine and sine series terms, with ceil(log2) of each.
    localparam int COS_DIV [1:6] = '{2, 12, 30, 56, 90, 132};
    localparam int COS_LOG [1:6] = '{1, 4, 5, 6, 7, 8};
    localparam int SIN_DIV [1:6] = '{6, 20, 42, 72, 110, 1};
    localparam int SIN_LOG [1:6] = '{3, 5, 6, 7, 7, 0};

    typedef struct packed {
        logic [1:0]         q;
        logic               swap;
        logic [31:0]        x2;
        logic [32:0]        tc;
        logic [32:0]        ts;
        logic [31:0]        pc;
        logic [31:0]        ps;
        logic signed [35:0] c;
        logic signed [35:0] s;
    } t_trig;

    typedef struct packed {
        logic [33:0] cm;
        logic        cn;
        logic [33:0] sm;
        logic        sn;
    } t_tmag;

    function automatic logic [5:0] f_tz(input logic [63:0] w);
        logic [63:0] low;
        logic [5:0]  idx;
        low = w & (~w + 64'd1);
        idx = '0;
        for (int b = 0; b < 6; b++) begin
            for (int i = 0; i < 64; i++) begin
                if (((i >> b) & 1) == 1) begin
                    idx[b] = idx[b] | low[i];
                end
            end
        end
        return idx;
    endfunction

    function automatic logic [31:0] f_sat(input logic [63:0] mag, input logic neg);
        logic [63:0] m;
        m = (mag + (64'd1 << (RND_SH - 1))) >> RND_SH;
        if (neg) begin
            if (m >= 64'h8000_0000) begin
                return 32'h8000_0000;
            end
            return 32'd0 - m[31:0];
        end
        if (m > 64'h7FFF_FFFF) begin
            return 32'h7FFF_FFFF;
        end
        return m[31:0];
    endfunction

endpackage

### hdl/box_muller_normal_pair.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_muller_normal_pair
// Pipelined Box-Muller sampler giving a pair of normal samples per word.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle; the 32 log2 squaring stages and the 32
// square-root stages are fully pipelined, and the whole pipe halts together
// while the output word waits. Reset clears all valid bits and sets the
// scale register to 1024; no clearing pass is needed.
// ----------------------------------------------------------------------------
module box_muller_normal_pair
    import bmnp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [12:0]  i_cfg_wdata,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [255:0] i_s_tdata,   // u_word, v_word, e_low, e_high
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [63:0]  o_m_tdata    // sample_cos, sample_sin
);

    logic w_adv;
    logic [N_STAGES-1:0] r_vld;
    logic [12:0] r_scale;

    logic [63:0] w_u, w_v, w_el, w_eh;
    logic [6:0]  n_cnt;

    logic [31:0] r_lx  [0:LOG_STEPS];
    logic [31:0] r_ly  [0:LOG_STEPS];
    logic [6:0]  r_cnt [0:LOG_STEPS];
    logic [31:0] r_phase;

    logic [39:0] r_t;
    logic [52:0] r_a;
    logic [52:0] r_ph;
    logic [63:0] r_pl;
    logic [63:0] r_rem [0:SQRT_STEPS];
    logic [63:0] r_res [0:SQRT_STEPS];

    logic [1:0]  r_q;
    logic        r_swap;
    logic [29:0] r_rr;
    logic [1:0]  r_q2;
    logic        r_swap2;
    logic [31:0] r_x;
    t_trig       r_tr  [0:2*TERMS+1];
    t_tmag       r_tdl [0:TRIG_DLY-1];

    logic [63:0] r_mc, r_ms;
    logic        r_nc, r_ns;
    logic [31:0] r_oc, r_os;

    assign w_adv      = !r_vld[N_STAGES-1] || i_m_tready;
    assign o_s_tready = w_adv;
    assign o_m_tvalid = r_vld[N_STAGES-1];
    assign o_m_tdata  = {r_os, r_oc};

    assign w_u  = i_s_tdata[63:0];
    assign w_v  = i_s_tdata[127:64];
    assign w_el = i_s_tdata[191:128];
    assign w_eh = i_s_tdata[255:192];

    always_comb begin
        if (w_el != 64'd0) begin
            n_cnt = {1'b0, f_tz(w_el)};
        end else if (w_eh != 64'd0) begin
            n_cnt = {1'b1, f_tz(w_eh)};
        end else begin
            n_cnt = 7'd63;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_scale <= SCALE_RST;
        end else begin
            if (i_cfg_we) begin
                r_scale <= i_cfg_wdata;
            end
            if (w_adv) begin
                r_vld <= {r_vld[N_STAGES-2:0], i_s_tvalid};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_lx[0]  <= {1'b1, w_v[52:22]};
            r_ly[0]  <= '0;
            r_cnt[0] <= n_cnt;
            r_phase  <= w_u[52:21];
        end
    end

    for (genvar i = 0; i < LOG_STEPS; i++) begin : g_log
        logic [63:0] w_sq;
        assign w_sq = {32'd0, r_lx[i]} * {32'd0, r_lx[i]};
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_lx[i+1]  <= w_sq[63] ? w_sq[63:32] : w_sq[62:31];
                r_ly[i+1]  <= {r_ly[i][30:0], w_sq[63]};
                r_cnt[i+1] <= r_cnt[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_t      <= {{1'b0, r_cnt[LOG_STEPS]} + 8'd1, 32'd0} - {8'd0, r_ly[LOG_STEPS]};
            r_a      <= {40'd0, r_scale} * {13'd0, r_t};
            r_ph     <= {32'd0, r_a[52:32]} * {21'd0, LN2_Q32};
            r_pl     <= {32'd0, r_a[31:0]} * {32'd0, LN2_Q32};
            r_rem[0] <= {3'd0, r_ph, 8'd0} + {24'd0, r_pl[63:24]};
            r_res[0] <= '0;
        end
    end

    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
        logic [63:0] w_sum;
        assign w_sum = r_res[j] + BIT;
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                if (r_rem[j] >= w_sum) begin
                    r_rem[j+1] <= r_rem[j] - w_sum;
                    r_res[j+1] <= (r_res[j] >> 1) + BIT;
                end else begin
                    r_rem[j+1] <= r_rem[j];
                    r_res[j+1] <= r_res[j] >> 1;
                end
            end
        end
    end

    logic [64:0] w_xp;
    logic [63:0] w_x2p;
    assign w_xp  = {35'd0, r_rr} * {30'd0, TWO_PI_Q32};
    assign w_x2p = {32'd0, r_x} * {32'd0, r_x};

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_q     <= r_phase[31:30];
            r_swap  <= r_phase[29];
            r_rr    <= r_phase[29] ? 30'(31'h4000_0000 - {1'b0, r_phase[29:0]})
                                   : r_phase[29:0];
            r_q2    <= r_q;
            r_swap2 <= r_swap;
            r_x     <= w_xp[63:32];
            r_tr[0] <= '{q: r_q2, swap: r_swap2, x2: w_x2p[63:32], tc: 33'h1_0000_0000,
                         ts: {1'b0, r_x}, pc: '0, ps: '0, c: '0, s: '0};
        end
    end

    for (genvar n = 1; n <= TERMS; n++) begin : g_term
        localparam logic [63:0] MC = ((64'd1 << (32 + COS_LOG[n])) + COS_DIV[n] - 1) / COS_DIV[n];
        localparam logic [63:0] MS = ((64'd1 << (32 + SIN_LOG[n])) + SIN_DIV[n] - 1) / SIN_DIV[n];
        logic [64:0] w_pc, w_ps, w_dc, w_ds;
        t_trig n_p, n_d;
        assign w_pc = {32'd0, r_tr[2*n-2].tc} * {33'd0, r_tr[2*n-2].x2};
        assign w_ps = {32'd0, r_tr[2*n-2].ts} * {33'd0, r_tr[2*n-2].x2};
        assign w_dc = {33'd0, r_tr[2*n-1].pc} * {32'd0, MC[32:0]};
        assign w_ds = {33'd0, r_tr[2*n-1].ps} * {32'd0, MS[32:0]};
        always_comb begin
            n_p    = r_tr[2*n-2];
            n_p.pc = w_pc[63:32];
            n_p.ps = w_ps[63:32];
            if (((n - 1) % 2) == 0) begin
                n_p.c = r_tr[2*n-2].c + $signed({3'd0, r_tr[2*n-2].tc});
                n_p.s = r_tr[2*n-2].s + $signed({3'd0, r_tr[2*n-2].ts});
            end else begin
                n_p.c = r_tr[2*n-2].c - $signed({3'd0, r_tr[2*n-2].tc});
                n_p.s = r_tr[2*n-2].s - $signed({3'd0, r_tr[2*n-2].ts});
            end
            n_d    = r_tr[2*n-1];
            n_d.tc = {1'b0, 32'(w_dc >> (32 + COS_LOG[n]))};
            if (n < TERMS) begin
                n_d.ts = {1'b0, 32'(w_ds >> (32 + SIN_LOG[n]))};
            end else begin
                n_d.ts = '0;
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_tr[2*n-1] <= n_p;
                r_tr[2*n]   <= n_d;
            end
        end
    end

    logic signed [35:0] w_a, w_b;
    logic [33:0] w_am, w_bm;
    logic        w_an, w_bn;
    t_tmag       n_rot;
    t_trig       n_fin;

    always_comb begin
        n_fin   = r_tr[2*TERMS];
        n_fin.c = r_tr[2*TERMS].c + $signed({3'd0, r_tr[2*TERMS].tc});
    end

    always_comb begin
        w_a  = r_tr[2*TERMS+1].swap ? r_tr[2*TERMS+1].s : r_tr[2*TERMS+1].c;
        w_b  = r_tr[2*TERMS+1].swap ? r_tr[2*TERMS+1].c : r_tr[2*TERMS+1].s;
        w_an = w_a[35];
        w_bn = w_b[35];
        w_am = 34'(w_an ? -w_a : w_a);
        w_bm = 34'(w_bn ? -w_b : w_b);
        case (r_tr[2*TERMS+1].q)
            2'd0: n_rot = '{cm: w_am, cn: w_an, sm: w_bm, sn: w_bn};
            2'd1: n_rot = '{cm: w_bm, cn: !w_bn, sm: w_am, sn: w_an};
            2'd2: n_rot = '{cm: w_am, cn: !w_an, sm: w_bm, sn: !w_bn};
            default: n_rot = '{cm: w_bm, cn: w_bn, sm: w_am, sn: !w_an};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_tr[2*TERMS+1]   <= n_fin;
            r_tdl[0]          <= n_rot;
            for (int k = 1; k < TRIG_DLY; k++) begin
                r_tdl[k] <= r_tdl[k-1];
            end
            r_mc <= 64'({34'd0, r_res[SQRT_STEPS][31:0]} * {32'd0, r_tdl[TRIG_DLY-1].cm});
            r_ms <= 64'({34'd0, r_res[SQRT_STEPS][31:0]} * {32'd0, r_tdl[TRIG_DLY-1].sm});
            r_nc <= r_tdl[TRIG_DLY-1].cn;
            r_ns <= r_tdl[TRIG_DLY-1].sn;
            r_oc <= f_sat(r_mc, r_nc);
            r_os <= f_sat(r_ms, r_ns);
        end
    end

endmodule

### dv/box_muller_normal_pair_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_muller_normal_pair_chk
// Watches the input, output and scale register ports of the sampler, predicts
// the normal pair for every accepted input word and compares it, field by
// field, with the output words in order.
// ----------------------------------------------------------------------------
module box_muller_normal_pair_chk
    import bmnp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [12:0]  i_cfg_wdata,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [255:0] i_s_tdata,   // u_word, v_word, e_low, e_high
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [63:0]  i_m_tdata,   // sample_cos, sample_sin
    output int           o_errors,
    output int           o_pending
);

    logic [12:0] scale_d;
    logic [63:0] pair_q[$];

    function automatic logic [63:0] geo_count(input logic [63:0] lo, input logic [63:0] hi);
        logic [63:0] w;
        logic [63:0] n;
        logic [63:0] base;
        if (lo != 0) begin
            w = lo;
            base = 0;
        end else if (hi != 0) begin
            w = hi;
            base = 64;
        end else begin
            return 64'd63;
        end
        n = 0;
        while (n < 63 && w[n] == 1'b0) begin
            n++;
        end
        return base + n;
    endfunction

    function automatic logic [63:0] log2_q32(input logic [52:0] f);
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] sq;
        x = ((64'd1 << 53) + 64'(f)) >> 22;
        y = 0;
        for (int i = 0; i < 32; i++) begin
            sq = x * x;
            y = y << 1;
            if (sq[63]) begin
                y[0] = 1'b1;
                x = sq >> 32;
            end else begin
                x = sq >> 31;
            end
        end
        return y;
    endfunction

    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) begin
            bitv = bitv >> 2;
        end
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] round_sat(input logic [63:0] rad, input longint trig);
        logic        neg;
        logic [63:0] ab;
        logic [63:0] m;
        neg = trig < 0;
        ab = neg ? 64'(-trig) : 64'(trig);
        m = (rad * ab + (64'd1 << (51 - FRAC_BITS))) >> (52 - FRAC_BITS);
        if (neg) begin
            if (m >= 64'h8000_0000) begin
                return 32'h8000_0000;
            end
            return 32'd0 - m[31:0];
        end
        if (m > 64'h7FFF_FFFF) begin
            return 32'h7FFF_FFFF;
        end
        return m[31:0];
    endfunction

    function automatic logic [63:0] normal_pair(input logic [255:0] w, input logic [12:0] d);
        logic [63:0] cnt;
        logic [63:0] t;
        logic [63:0] a;
        logic [63:0] r2;
        logic [63:0] rad;
        logic [31:0] phase;
        logic [63:0] rr;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] tc;
        logic [63:0] ts;
        logic        swap;
        longint      c;
        longint      s;
        longint      pa;
        longint      pb;
        longint      co;
        longint      si;
        cnt = geo_count(w[191:128], w[255:192]);
        t = ((cnt + 1) << 32) - log2_q32(w[116:64]);
        a = 64'(d) * t;
        r2 = (((a >> 32) * 64'hB172_17F8) << 8) + ((64'(a[31:0]) * 64'hB172_17F8) >> 24);
        rad = root_floor(r2);

        phase = w[52:21];
        swap = phase[29];
        rr = swap ? (64'd1 << 30) - 64'(phase[29:0]) : 64'(phase[29:0]);
        x = (rr * 64'h6_487E_D511) >> 32;
        x2 = (x * x) >> 32;
        c = longint'(64'd1 << 32);
        s = longint'(x);
        tc = 64'd1 << 32;
        ts = x;
        for (int n = 1; n <= 6; n++) begin
            tc = ((tc * x2) >> 32) / 64'((2 * n - 1) * (2 * n));
            c = (n % 2 == 1) ? c - longint'(tc) : c + longint'(tc);
        end
        for (int n = 1; n <= 5; n++) begin
            ts = ((ts * x2) >> 32) / 64'((2 * n) * (2 * n + 1));
            s = (n % 2 == 1) ? s - longint'(ts) : s + longint'(ts);
        end
        pa = swap ? s : c;
        pb = swap ? c : s;
        case (phase[31:30])
            2'd0: begin co = pa;  si = pb;  end
            2'd1: begin co = -pb; si = pa;  end
            2'd2: begin co = -pa; si = -pb; end
            default: begin co = pb; si = -pa; end
        endcase
        return {round_sat(rad, si), round_sat(rad, co)};
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on %s at %0t: got %h, expected %h", field, $time, got, want);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
    end

    assign o_pending = pair_q.size();

    always @(posedge i_clk) begin
        logic [63:0] want;
        if (!i_rst_n) begin
            scale_d <= SCALE_RST;
            pair_q.delete();
        end else begin
            if (i_cfg_we) begin
                scale_d <= i_cfg_wdata;
            end
            if (i_s_tvalid && i_s_tready) begin
                pair_q.push_back(normal_pair(i_s_tdata, scale_d));
            end
            if (i_m_tvalid && i_m_tready) begin
                if (pair_q.size() == 0) begin
                    $display("unexpected output word %h at %0t", i_m_tdata, $time);
                    o_errors++;
                end else begin
                    want = pair_q.pop_front();
                    if (i_m_tdata[31:0] !== want[31:0]) begin
                        report_mismatch("sample_cos", i_m_tdata[31:0], want[31:0]);
                    end
                    if (i_m_tdata[63:32] !== want[63:32]) begin
                        report_mismatch("sample_sin", i_m_tdata[63:32], want[63:32]);
                    end
                end
            end
        end
    end

endmodule

### dv/box_muller_normal_pair_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_muller_normal_pair_tb
// Drives directed and random words into the sampler over several scale
// settings and idle patterns, including a long output stall, while a checker
// compares every output pair with its own prediction.
// ----------------------------------------------------------------------------
module box_muller_normal_pair_tb;
    import bmnp_pkg::*;

    localparam int STALL_LIMIT = 5000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [12:0]  i_cfg_wdata = '0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [255:0] i_s_tdata = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [63:0]  o_m_tdata;

    int errors;
    int pending;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;
    int hold_left = 0;
    int quiet_cycles = 0;

    always #4 i_clk = ~i_clk;

    box_muller_normal_pair u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    box_muller_normal_pair_chk u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_m_tdata   (o_m_tdata),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // The one long hold-off lets the pipe fill and back up into the input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= 400;
            i_m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand_geo_word();
        case ($urandom_range(7))
            0: return 64'd0;
            1: return 64'd1 << $urandom_range(63);
            2: return rand64() << $urandom_range(63);
            default: return rand64();
        endcase
    endfunction

    task automatic push_word(input logic [255:0] w);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= w;
        @(posedge i_clk);
        while (!o_s_tready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic drain_and_set_scale(input logic [12:0] d);
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= d;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    logic [12:0] scales [7];
    logic [63:0] ones;

    initial begin
        ones = '1;
        scales = '{13'd2, 13'd4096, 13'd0, 13'h1FFF, 13'd1023, 13'd64, 13'd1024};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words under the reset scale of 1024.
        push_word({64'd0, 64'd0, 64'd0, 64'd0});
        push_word({ones, ones, ones, ones});
        push_word({64'd0, 64'd1, 64'd0, 64'd0});
        push_word({64'd0, 64'd1 << 63, 64'd0, 64'h0000_0000_0020_0000});
        push_word({64'd1 << 63, 64'd0, 64'h1F_FFFF_FFFF_FFFF, 64'h0000_4000_0000_0000});
        push_word({64'd1, 64'd0, 64'd0, 64'h0008_0000_0000_0000});
        push_word({ones, 64'd1 << 63, 64'd0, 64'h0010_0000_0000_0000});
        push_word({64'd0, 64'd1 << 62, 64'd1 << 52, 64'h0018_0000_0000_0000});
        push_word({64'd5, 64'd2, ones, 64'h000C_0000_0000_0000});
        push_word({64'd0, 64'd4, 64'hFFE0_0000_0000_0000, 64'h0007_FFFF_FFE0_0000});
        push_word({rand64(), 64'd1 << 63, 64'd0, 64'h0004_0000_0000_0000});
        push_word({rand64(), 64'd1 << 31, rand64(), 64'h0014_0000_0000_0000});
        push_word({rand64(), ones, 64'd1, 64'h001C_0000_0000_0000});
        push_word({ones, ones, ones, 64'h001F_FFFF_FFFF_FFFF});
        push_word({64'd0, 64'd0, 64'd0, 64'h0000_0000_0000_0001});

        for (int ph = 0; ph < 7; ph++) begin
            drain_and_set_scale(scales[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            if (ph == 1) begin
                send_idle_pct = 0;
                hold_req <= 1'b1;
            end
            for (int i = 0; i < 200; i++) begin
                push_word({rand_geo_word(), rand_geo_word(), rand64(), rand64()});
            end
        end

        i_s_tvalid <= 1'b0;
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (80) @(posedge i_clk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
